// ----- src/best_fit_partition_allocator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the best-fit partition allocator
// Shared clocking and reset gating for the port checker.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BFPA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BFPA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/bfpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared constants, codes and control types of the partition allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

	localparam int MAX_PARTITIONS_DEF = 16;
	localparam int ADDR_BITS_DEF      = 16;
	localparam int OWNER_BITS_DEF     = 8;
	localparam int RESET_MEMORY       = 1024;

	localparam int ID_W      = 16;
	localparam int REQ_W     = 16;
	localparam int OWNER_IN_W = 8;
	localparam int CFG_W     = 16;
	localparam int STATUS_W  = 2;
	localparam int ADDR_OUT_W = 16;
	localparam int FREED_W   = 5;

	// valid, allocated and id bits of one table entry
	localparam int ENTRY_FIXED_W = 2 + ID_W;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 40;

	localparam int M_STATUS_LO = 0;
	localparam int M_ADDR_LO   = M_STATUS_LO + STATUS_W;
	localparam int M_PID_LO    = M_ADDR_LO + ADDR_OUT_W;
	localparam int M_FREED_LO  = M_PID_LO + ID_W;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FIT     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_OWNER   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd3;

	typedef struct packed {
		logic init;
		logic shift;
		logic pack;
		logic phase;
	} cell_ctl_t;

endpackage

// ----- src/bfpa_cell.sv -----
// ----------------------------------------------------------------------------
// bfpa_cell
// One table entry of the ring: loads, shifts toward the head, or swaps with
// a neighbor to squeeze empty entries to the tail.
// ----------------------------------------------------------------------------
module bfpa_cell import bfpa_pkg::*; #(
	parameter int ADDR_BITS  = ADDR_BITS_DEF,
	parameter int OWNER_BITS = OWNER_BITS_DEF,
	parameter bit HEAD       = 1'b0,
	parameter bit ODD        = 1'b0,
	localparam int EW = ENTRY_FIXED_W + OWNER_BITS + 2 * ADDR_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctl_t            ctl,
	input  logic [ADDR_BITS-1:0] init_size,
	input  logic [EW-1:0]        hi_in,
	input  logic [EW-1:0]        lo_in,
	output logic [EW-1:0]        q
);

	typedef struct packed {
		logic                  v;
		logic                  alloc;
		logic [OWNER_BITS-1:0] owner;
		logic [ADDR_BITS-1:0]  start;
		logic [ADDR_BITS-1:0]  size;
		logic [ID_W-1:0]       id;
	} entry_t;

	// the head cell comes out of reset as one free entry over all memory
	localparam entry_t RST_ENT = '{
		v:       HEAD,
		size:    (HEAD ? ADDR_BITS'(RESET_MEMORY) : '0),
		default: '0
	};

	entry_t hi, lo, ent_q, ent_d;

	assign hi = hi_in;
	assign lo = lo_in;
	assign q  = ent_q;

	always_comb begin
		ent_d = ent_q;
		if (ctl.init) begin
			ent_d = '0;
			if (HEAD) begin
				ent_d.v    = 1'b1;
				ent_d.size = init_size;
			end
		end else if (ctl.shift) begin
			ent_d = hi;
		end else if (ctl.pack) begin
			if (ODD == ctl.phase) begin
				if (!ent_q.v && hi.v) ent_d = hi;
			end else begin
				if (ent_q.v && !lo.v) ent_d = lo;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= RST_ENT;
		end else begin
			ent_q <= ent_d;
		end
	end

endmodule

// ----- src/best_fit_partition_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// best_fit_partition_allocator_unit
// Best-fit partition allocator with coalescing on free, table held in a ring
// of cells that rotates past a single head reader.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  s       | in  | s_tvalid/s_tready | s_tuser op, s_tdata owner_id, request_size
//  m       | out | m_tvalid/m_tready | m_tdata status, start, id, freed_count
//  cfg     | in  | cfg_we            | cfg_wdata total_memory
//
// Allocate: a scan rotation, then a write rotation;
// a rejected allocate skips the write rotation.
// Free: a rotation, plus an odd-even swap pass over the cells when entries
// merge. One request in flight at a time.
// Reset leaves one free entry of 1024 bytes; a cfg write reloads the table.
// A stalled result waits in the output register; the next word is taken
// once the current one has moved into that register.
// ----------------------------------------------------------------------------
module best_fit_partition_allocator_unit import bfpa_pkg::*; #(
	parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF,
	parameter int ADDR_BITS      = ADDR_BITS_DEF,
	parameter int OWNER_BITS     = OWNER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // owner_id[7:0], request_size[23:8]
	input  logic [0:0]           s_tuser,  // op[0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// status[1:0], start_address[17:2], partition_id[33:18], freed_count[38:34]
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int N    = MAX_PARTITIONS;
	localparam int IW   = $clog2(N);
	localparam int CNTW = $clog2(N + 1);
	localparam int CW   = (ADDR_BITS > REQ_W) ? ADDR_BITS : REQ_W;
	localparam int EW   = ENTRY_FIXED_W + OWNER_BITS + 2 * ADDR_BITS;

	localparam logic [CNTW-1:0] CNT_LAST = CNTW'(N - 1);
	localparam logic [CNTW-1:0] CNT_FULL = CNTW'(N);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_DEC   = 3'd2;
	localparam logic [2:0] S_WRITE = 3'd3;
	localparam logic [2:0] S_FREE  = 3'd4;
	localparam logic [2:0] S_PACK  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	typedef struct packed {
		logic                  v;
		logic                  alloc;
		logic [OWNER_BITS-1:0] owner;
		logic [ADDR_BITS-1:0]  start;
		logic [ADDR_BITS-1:0]  size;
		logic [ID_W-1:0]       id;
	} entry_t;

	entry_t cells [N];
	entry_t head, tail, a_mod, a_rem, f_ent, edge_lo, acc_q, carry_q;
	cell_ctl_t ctl;

	logic [2:0]            state_q;
	logic [CNTW-1:0]       cnt_q, freed_q, merged_q, count_q;
	logic [IW-1:0]         best_q, step;
	logic [CW-1:0]         brem_q, rem, hsize, reqx;
	logic                  found_q, cand, f_hit, mrg;
	logic [OWNER_BITS-1:0] owner_q;
	logic [REQ_W-1:0]      req_q;
	logic [ID_W-1:0]       next_id_q, nid_inc;
	logic [ADDR_BITS-1:0]  acc_end;

	logic [STATUS_W-1:0]   rs_status_q;
	logic [ADDR_OUT_W-1:0] rs_addr_q;
	logic [ID_W-1:0]       rs_pid_q;
	logic [FREED_W-1:0]    rs_freed_q;
	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;

	// the low edge of the chain looks occupied so the head never takes it
	assign edge_lo = '{v: 1'b1, default: '0};

	for (genvar i = 0; i < N; i++) begin : g_cell
		bfpa_cell #(
			.ADDR_BITS  (ADDR_BITS),
			.OWNER_BITS (OWNER_BITS),
			.HEAD       (i == 0),
			.ODD        (1'(i % 2))
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.init_size (ADDR_BITS'(cfg_wdata)),
			.hi_in     ((i == N - 1) ? tail : cells[(i + 1) % N]),
			.lo_in     ((i == 0) ? edge_lo : cells[(i + N - 1) % N]),
			.q         (cells[i])
		);
	end

	assign head  = cells[0];
	assign step  = cnt_q[IW-1:0];
	assign hsize = CW'(head.size);
	assign reqx  = CW'(req_q);
	assign rem   = hsize - reqx;
	assign cand  = head.v && !head.alloc && (req_q != '0) && (hsize >= reqx);

	always_comb begin
		a_mod       = head;
		a_mod.alloc = 1'b1;
		a_mod.owner = owner_q;
		a_mod.size  = ADDR_BITS'(req_q);
		a_mod.id    = next_id_q;
		a_rem       = '0;
		a_rem.v     = 1'b1;
		a_rem.start = head.start + ADDR_BITS'(req_q);
		a_rem.size  = ADDR_BITS'(brem_q);
	end

	assign f_hit = head.v && head.alloc && (head.owner == owner_q);

	always_comb begin
		f_ent = head;
		if (f_hit) begin
			f_ent.alloc = 1'b0;
			f_ent.owner = '0;
			f_ent.id    = '0;
		end
	end

	assign acc_end = acc_q.start + acc_q.size;
	assign mrg = acc_q.v && f_ent.v && !acc_q.alloc && !f_ent.alloc
		&& (acc_end == f_ent.start);

	assign nid_inc = next_id_q + 1'b1;

	// word pushed into the tail cell while the ring rotates
	always_comb begin
		case (state_q)
			S_WRITE: begin
				if (step == best_q) tail = a_mod;
				else if (step > best_q && brem_q != '0) tail = carry_q;
				else tail = head;
			end
			S_FREE: begin
				if (cnt_q == '0) tail = '0;
				else if (cnt_q == CNT_FULL) tail = acc_q;
				else if (mrg) tail = '0;
				else tail = acc_q;
			end
			S_PACK:  tail = '0;
			default: tail = head;
		endcase
	end

	always_comb begin
		ctl.init  = cfg_we;
		ctl.shift = (state_q == S_SCAN) || (state_q == S_WRITE) || (state_q == S_FREE);
		ctl.pack  = (state_q == S_PACK);
		ctl.phase = cnt_q[0];
	end

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			count_q     <= CNTW'(1);
			next_id_q   <= ID_W'(1);
			found_q     <= 1'b0;
			freed_q     <= '0;
			merged_q    <= '0;
			best_q      <= '0;
			brem_q      <= '0;
			carry_q     <= '0;
			acc_q       <= '0;
			rs_status_q <= '0;
			rs_addr_q   <= '0;
			rs_pid_q    <= '0;
			rs_freed_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						count_q   <= CNTW'(1);
						next_id_q <= ID_W'(1);
					end
					if (s_tvalid) begin
						cnt_q      <= '0;
						found_q    <= 1'b0;
						freed_q    <= '0;
						merged_q   <= '0;
						rs_addr_q  <= '0;
						rs_pid_q   <= '0;
						rs_freed_q <= '0;
						state_q    <= (s_tuser[0] == OP_ALLOC) ? S_SCAN : S_FREE;
					end
				end
				S_SCAN: begin
					if (cand && (!found_q || rem < brem_q)) begin
						found_q <= 1'b1;
						best_q  <= step;
						brem_q  <= rem;
					end
					if (cnt_q == CNT_LAST) state_q <= S_DEC;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_DEC: begin
					cnt_q <= '0;
					if (!found_q) begin
						rs_status_q <= ST_NO_FIT;
						state_q     <= S_DONE;
					end else if (brem_q != '0 && count_q == CNT_FULL) begin
						rs_status_q <= ST_TABLE_FULL;
						state_q     <= S_DONE;
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (step == best_q) begin
						rs_addr_q <= ADDR_OUT_W'(head.start);
						carry_q   <= a_rem;
					end else if (step > best_q) begin
						carry_q <= head;
					end
					if (cnt_q == CNT_LAST) begin
						rs_status_q <= ST_OK;
						rs_pid_q    <= next_id_q;
						next_id_q   <= (nid_inc == '0) ? ID_W'(1) : nid_inc;
						if (brem_q != '0) count_q <= count_q + 1'b1;
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FREE: begin
					if (cnt_q != CNT_FULL) begin
						if (f_hit) freed_q <= freed_q + 1'b1;
						if (cnt_q != '0 && mrg) begin
							acc_q.size <= acc_q.size + f_ent.size;
							merged_q   <= merged_q + 1'b1;
						end else begin
							acc_q <= f_ent;
						end
						cnt_q <= cnt_q + 1'b1;
					end else begin
						cnt_q      <= '0;
						rs_freed_q <= FREED_W'(freed_q);
						rs_status_q <= (freed_q == '0) ? ST_NO_OWNER : ST_OK;
						count_q    <= count_q - merged_q;
						state_q    <= (merged_q == '0) ? S_DONE : S_PACK;
					end
				end
				S_PACK: begin
					if (cnt_q == CNT_LAST) state_q <= S_DONE;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// load the output register when free, drop the word once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// payload side: capture request and assemble the output word
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			owner_q <= OWNER_BITS'(s_tdata[OWNER_IN_W-1:0]);
			req_q   <= s_tdata[OWNER_IN_W +: REQ_W];
		end
		if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {1'b0, rs_freed_q, rs_pid_q, rs_addr_q, rs_status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- src/bfpa_checker.sv -----
// ----------------------------------------------------------------------------
// bfpa_checker
// Port-level checks of the partition allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "best_fit_partition_allocator_unit_defines.svh"

module bfpa_checker import bfpa_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	logic [STATUS_W-1:0] st;
	assign st = m_tdata[M_STATUS_LO +: STATUS_W];

	// one request at a time: taking a word closes the input
	`BFPA_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input open while busy")

	`BFPA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word dropped")

	// only a granted allocate carries an address or an id
	`BFPA_ASSERT_NOW(a_no_grant_fields, m_tvalid && st != ST_OK, m_tdata[M_PID_LO +: ID_W] == '0 && m_tdata[M_ADDR_LO +: ADDR_OUT_W] == '0, "grant fields on failure")

	`BFPA_ASSERT_NOW(a_fail_no_freed, m_tvalid && st != ST_OK, m_tdata[M_FREED_LO +: FREED_W] == '0, "freed count on failure")

endmodule

bind best_fit_partition_allocator_unit bfpa_checker u_bfpa_checker (.*);
